FILE: design/spq_pkg.sv
// Package for the sorted priority queue: sizes, codes and beat/slot types.
// No dependencies; used by every module of the queue.
`default_nettype none
package spq_pkg;

    localparam int DEPTH    = 16;
    localparam int KEY_BITS = 16;
    localparam int TAG_BITS = 16;
    localparam int OCC_BITS = 5;

    localparam logic FN_INSERT  = 1'b0;
    localparam logic FN_DEQUEUE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                func;
        logic [KEY_BITS-1:0] prio_key;
        logic [KEY_BITS-1:0] second_key;
        logic [TAG_BITS-1:0] entry_tag;
    } t_in_beat;

    typedef struct packed {
        logic                head_valid;
        logic [KEY_BITS-1:0] out_prio;
        logic [KEY_BITS-1:0] out_second;
        logic [TAG_BITS-1:0] out_tag;
        logic [1:0]          status;
        logic [OCC_BITS-1:0] occupancy;
    } t_out_beat;

    // one stored entry as it moves along the chain
    typedef struct packed {
        logic                used;
        logic [KEY_BITS-1:0] prio;
        logic [KEY_BITS-1:0] second;
        logic [TAG_BITS-1:0] tag;
    } t_slot;

    // operation broadcast to every cell
    typedef struct packed {
        logic  ins;
        logic  deq;
        t_slot new_slot;
    } t_cell_ctrl;

endpackage
`default_nettype wire

FILE: design/spq_cell.sv
// One slot of the sorted chain: holds an entry, compares it with the broadcast
// key and shifts toward or away from the head. Depends on spq_pkg.
`default_nettype none
module spq_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire spq_pkg::t_cell_ctrl i_ctrl,
    input  wire spq_pkg::t_slot      i_left,
    input  wire logic                i_left_goes,
    input  wire spq_pkg::t_slot      i_right,
    output spq_pkg::t_slot           o_slot,
    output logic                     o_goes
);

    logic                         r_used;
    logic [spq_pkg::KEY_BITS-1:0] r_prio;
    logic [spq_pkg::KEY_BITS-1:0] r_second;
    logic [spq_pkg::TAG_BITS-1:0] r_tag;
    spq_pkg::t_slot               n_slot;
    logic                         w_less;

    // strict compare keeps equal keys in arrival order
    assign w_less = (i_ctrl.new_slot.prio < r_prio) ||
                    ((i_ctrl.new_slot.prio == r_prio) &&
                     (i_ctrl.new_slot.second < r_second));
    assign o_goes = !r_used || w_less;

    assign o_slot = '{used: r_used, prio: r_prio, second: r_second, tag: r_tag};

    always_comb begin
        n_slot = o_slot;
        if (i_ctrl.ins && o_goes) begin
            if (i_left_goes) begin
                n_slot = i_left;
            end else begin
                n_slot = i_ctrl.new_slot;
            end
        end else if (i_ctrl.deq) begin
            n_slot = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else begin
            r_used <= n_slot.used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio   <= n_slot.prio;
        r_second <= n_slot.second;
        r_tag    <= n_slot.tag;
    end

endmodule
`default_nettype wire

FILE: design/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: chain of spq_cell slots, occupancy
// counter and output register. Depends on spq_pkg and spq_cell.
//
//   channel | direction | handshake                  | payload
//   in      | input     | i_in_valid / o_in_ready    | i_in_data  (spq_pkg::t_in_beat)
//   out     | output    | o_out_valid / i_out_ready  | o_out_data (spq_pkg::t_out_beat)
//
// One beat per cycle unless a stalled output holds it back: every cell compares
// against the new key at once and the chain shifts one place, so an operation finishes
// in the cycle it is accepted. Its result shows in the output register the cycle after.
// Reset empties the chain and the output register; no clearing pass.
// A stalled output blocks new beats only while its register is still full.
`default_nettype none
module sorted_priority_queue_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire spq_pkg::t_in_beat i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output spq_pkg::t_out_beat     o_out_data
);

    spq_pkg::t_slot      w_slot [spq_pkg::DEPTH];
    logic                w_goes [spq_pkg::DEPTH];
    spq_pkg::t_cell_ctrl w_ctrl;
    logic                w_fire;
    logic                w_full;
    logic                w_empty;

    logic [spq_pkg::OCC_BITS-1:0] r_count;
    logic [spq_pkg::OCC_BITS-1:0] n_count;
    logic                         r_out_valid;
    spq_pkg::t_out_beat           r_out;
    spq_pkg::t_out_beat           n_out;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_fire     = i_in_valid && o_in_ready;
    assign w_full     = w_slot[spq_pkg::DEPTH-1].used;
    assign w_empty    = !w_slot[0].used;

    assign w_ctrl = '{
        ins: w_fire && (i_in_data.func == spq_pkg::FN_INSERT) && !w_full,
        deq: w_fire && (i_in_data.func == spq_pkg::FN_DEQUEUE) && !w_empty,
        new_slot: '{used: 1'b1, prio: i_in_data.prio_key,
                    second: i_in_data.second_key, tag: i_in_data.entry_tag}
    };

    for (genvar g = 0; g < spq_pkg::DEPTH; g++) begin : g_cell
        spq_pkg::t_slot w_left;
        spq_pkg::t_slot w_right;
        logic           w_left_goes;
        if (g == 0) begin : g_head
            assign w_left      = '0;
            assign w_left_goes = 1'b0;
        end else begin : g_mid
            assign w_left      = w_slot[g-1];
            assign w_left_goes = w_goes[g-1];
        end
        if (g == spq_pkg::DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_slot[g+1];
        end
        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_left      (w_left),
            .i_left_goes (w_left_goes),
            .i_right     (w_right),
            .o_slot      (w_slot[g]),
            .o_goes      (w_goes[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins) begin
            n_count = r_count + spq_pkg::OCC_BITS'(1);
        end else if (w_ctrl.deq) begin
            n_count = r_count - spq_pkg::OCC_BITS'(1);
        end
        n_out            = '0;
        n_out.occupancy  = n_count;
        n_out.status     = spq_pkg::ST_OK;
        if (i_in_data.func == spq_pkg::FN_INSERT) begin
            if (w_full) begin
                n_out.status = spq_pkg::ST_FULL;
            end
        end else if (w_empty) begin
            n_out.status = spq_pkg::ST_EMPTY;
        end else begin
            n_out.head_valid = 1'b1;
            n_out.out_prio   = w_slot[0].prio;
            n_out.out_second = w_slot[0].second;
            n_out.out_tag    = w_slot[0].tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

FILE: design/spq_checker.sv
// Port-level checks for sorted_priority_queue_unit, bound to the top level.
// Depends on spq_pkg.
`default_nettype none
module spq_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire spq_pkg::t_out_beat o_out_data
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

    a_head_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.head_valid |-> o_out_data.status == spq_pkg::ST_OK &&
            o_out_data.occupancy < spq_pkg::OCC_BITS'(spq_pkg::DEPTH))
        else $error("dequeued entry with bad status or occupancy");

    a_empty_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.head_valid |-> o_out_data.out_prio == '0 &&
            o_out_data.out_second == '0 && o_out_data.out_tag == '0)
        else $error("fields not cleared without head entry");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == spq_pkg::ST_FULL |->
            o_out_data.occupancy == spq_pkg::OCC_BITS'(spq_pkg::DEPTH))
        else $error("full drop reported below full occupancy");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire
